// ===== rtl/k_inverse_pair_permutation_count_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the inverse pair permutation count core
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef K_INVERSE_PAIR_PERMUTATION_COUNT_CORE_MACROS_SVH
`define K_INVERSE_PAIR_PERMUTATION_COUNT_CORE_MACROS_SVH

// Same-cycle implication
`define KIP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KIP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kip_pkg.sv =====
// ----------------------------------------------------------------------------
// kip_pkg
// Constants and types shared by the inverse pair permutation count core.
// ----------------------------------------------------------------------------
package kip_pkg;

  // Field widths
  localparam int LEN_W   = 11;
  localparam int COUNT_W = 30;

  // Default sizing
  localparam int DEF_MAX_N = 1024;
  localparam int DEF_MAX_K = 1024;

  // Modulus of the count
  localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_DRAIN,
    ST_FINISH
  } kip_state_t;

endpackage

// ===== rtl/kip_rowmem.sv =====
// ----------------------------------------------------------------------------
// kip_rowmem
// Row memory: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module kip_rowmem #(
  parameter int DEPTH = 1025,
  parameter int WIDTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read two entries
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/k_inverse_pair_permutation_count_core.sv =====
// Throughput: one request at a time, next can be accepted in the cycle after the result loads; cells
// pass through a three-stage read/modify/write pipe that drains after each row.
// Reset: rst clears the sequencer and output valid; the row memories are not cleared,
// since every row entry is written before its read value is used.
`include "k_inverse_pair_permutation_count_core_macros.svh"

// ----------------------------------------------------------------------------
// k_inverse_pair_permutation_count_core
// Counts permutations of length n with exactly k inverse pairs, modulo
// 1000000007, building the table row by row in two ping-pong row memories.
// ----------------------------------------------------------------------------
module k_inverse_pair_permutation_count_core #(
  parameter int MAX_N = kip_pkg::DEF_MAX_N,
  parameter int MAX_K = kip_pkg::DEF_MAX_K
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kip_pkg::LEN_W-1:0]   perm_length,
  input  logic [kip_pkg::LEN_W-1:0]   inversions,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kip_pkg::COUNT_W-1:0] count_mod
);

  import kip_pkg::*;

  localparam int AW    = $clog2(MAX_K + 1);
  localparam int RW    = $clog2(MAX_N + 1);
  localparam int TOP_W = $clog2(MAX_N * (MAX_N - 1) / 2 + 1);
  localparam int CW    = (AW > TOP_W) ? AW : TOP_W;
  localparam int IW    = (AW > RW) ? AW : RW;

  kip_state_t state, state_next;

  logic [RW-1:0]    n_reg;
  logic [AW-1:0]    k_reg;
  logic [RW-1:0]    row;
  logic [TOP_W-1:0] top;
  logic [AW-1:0]    col;
  logic             sel;

  logic             in_ready_int;
  logic             issue;
  logic             row_go;
  logic             load_out;
  logic             reject;
  logic             trivial;
  logic             pipe_empty;

  logic             col_zero;
  logic             col_sub;
  logic             col_last;
  logic [AW-1:0]    addr_b;

  logic             s1_vld;
  logic [AW-1:0]    s1_col;
  logic             s1_first;
  logic             s1_zero;
  logic             s1_sub;
  logic             s1_last;

  logic             s2_vld;
  logic [AW-1:0]    s2_col;
  logic             s2_first;
  logic             s2_zero;
  logic             s2_last;
  logic [COUNT_W-1:0] s2_d;

  logic [COUNT_W-1:0] last_val;
  logic [COUNT_W-1:0] res;
  logic [COUNT_W-1:0] s2_v;
  logic [COUNT_W:0]   s2_sum;
  logic [COUNT_W-1:0] s1_a;
  logic [COUNT_W-1:0] s1_b;
  logic [COUNT_W-1:0] s1_d;
  logic [COUNT_W:0]   s1_diff;

  logic [COUNT_W-1:0] r0_a, r0_b, r1_a, r1_b;

  // Classify the request
  assign reject  = (32'(perm_length) > 32'(MAX_N)) || (32'(inversions) > 32'(MAX_K));
  assign trivial = reject || (perm_length == '0);
  assign pipe_empty = !s1_vld && !s2_vld;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = trivial ? ST_FINISH : ST_ROW;
        end
      end
      ST_ROW: begin
        if (col_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = (row == n_reg) ? ST_FINISH : ST_ROW;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_int = 1'b0;
    issue        = 1'b0;
    row_go       = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE:   in_ready_int = 1'b1;
      ST_ROW:    issue = 1'b1;
      ST_DRAIN:  row_go = pipe_empty && (row != n_reg);
      ST_FINISH: load_out = !out_valid || out_ready;
      default: begin
        in_ready_int = 1'b0;
      end
    endcase
  end

  assign in_ready = in_ready_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Column flags at issue
  assign col_zero = CW'(col) > CW'(top);
  assign col_sub  = IW'(col) >= IW'(row);
  assign col_last = (col == k_reg);
  assign addr_b   = AW'(IW'(col) - IW'(row));

  // Request capture, row and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      sel <= 1'b0;
    end else if (in_valid && in_ready_int) begin
      n_reg <= RW'(perm_length);
      k_reg <= AW'(inversions);
      row   <= RW'(1);
      top   <= '0;
      col   <= '0;
      sel   <= 1'b0;
      if (reject) begin
        res <= '0;
      end else begin
        res <= (inversions == '0) ? COUNT_W'(1) : '0;
      end
    end else if (issue) begin
      if (!col_last) begin
        col <= col + AW'(1);
      end
    end else if (row_go) begin
      row <= row + RW'(1);
      top <= top + TOP_W'(row);
      col <= '0;
      sel <= ~sel;
    end else if (s2_vld && s2_last && (row == n_reg)) begin
      res <= s2_v;
    end
  end

  // Row memories: sel picks the row being written
  kip_rowmem #(.DEPTH(MAX_K + 1), .WIDTH(COUNT_W)) u_mem0 (
    .clk     (clk),
    .we      (s2_vld && !sel),
    .waddr   (s2_col),
    .wdata   (s2_v),
    .raddr_a (col),
    .raddr_b (addr_b),
    .rdata_a (r0_a),
    .rdata_b (r0_b)
  );

  kip_rowmem #(.DEPTH(MAX_K + 1), .WIDTH(COUNT_W)) u_mem1 (
    .clk     (clk),
    .we      (s2_vld && sel),
    .waddr   (s2_col),
    .wdata   (s2_v),
    .raddr_a (col),
    .raddr_b (addr_b),
    .rdata_a (r1_a),
    .rdata_b (r1_b)
  );

  // Stage 1: previous row difference
  assign s1_a    = sel ? r0_a : r1_a;
  assign s1_b    = s1_sub ? (sel ? r0_b : r1_b) : '0;
  assign s1_diff = {1'b0, s1_a} - {1'b0, s1_b};
  assign s1_d    = s1_diff[COUNT_W] ? (s1_diff[COUNT_W-1:0] + PRIME) : s1_diff[COUNT_W-1:0];

  // Stage 2: add the left neighbor and reduce
  assign s2_sum = {1'b0, s2_d} + {1'b0, last_val};
  always_comb begin
    if (s2_first) begin
      s2_v = COUNT_W'(1);
    end else if (s2_zero) begin
      s2_v = '0;
    end else if (s2_sum >= {1'b0, PRIME}) begin
      s2_v = COUNT_W'(s2_sum - {1'b0, PRIME});
    end else begin
      s2_v = s2_sum[COUNT_W-1:0];
    end
  end

  // Advance the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= issue;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_col   <= col;
    s1_first <= (col == '0);
    s1_zero  <= col_zero;
    s1_sub   <= col_sub;
    s1_last  <= col_last;
    s2_col   <= s1_col;
    s2_first <= s1_first;
    s2_zero  <= s1_zero;
    s2_last  <= s1_last;
    s2_d     <= s1_d;
    if (s2_vld) begin
      last_val <= s2_v;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      count_mod <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `KIP_ASSERT_IMP(a_count_range, out_valid, count_mod < PRIME, "count out of range")
  `KIP_ASSERT_IMP(a_idle_pipe_empty, in_ready, pipe_empty, "pipe busy while idle")
  `KIP_ASSERT_IMP(a_write_in_range, s2_vld, s2_col <= k_reg, "write beyond column k")
  `KIP_ASSERT_NEXT(a_finish_loads, load_out, out_valid && (state == ST_IDLE),
                   "finish did not present result")

endmodule
